### sv/thru_zero_flanger_core_assert.svh
// Assertion macros shared by the flanger RTL.
// Needs clk and rst_n in scope where a macro is used.
`ifndef THRU_ZERO_FLANGER_CORE_ASSERT_SVH
`define THRU_ZERO_FLANGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TZF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TZF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TZF_ASSERT_IMP(lbl, ante, cons, msg)
`define TZF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/tzf_pkg.sv
// Shared types and constants of the thru-zero flanger.
// No dependencies; used by every RTL file of the block.
package tzf_pkg;

  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int STEP_W      = 20;
  localparam int DLY_CFG_W   = 19;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 15;
  localparam int PHASE_W     = 32;
  localparam int FRAC_W      = 8;
  localparam int DELAY_W     = 20;
  localparam int WHOLE_W     = DELAY_W - FRAC_W;
  localparam int MUL_A_W     = PHASE_W + 1;
  localparam int PROD_A_W    = 2 * MUL_A_W;
  localparam int LANE_A_W    = GAIN_W + 1;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PHASE_STEP    = 3'd0;
  localparam cfg_index_t REG_DELAY_BASE    = 3'd1;
  localparam cfg_index_t REG_DELAY_SWING   = 3'd2;
  localparam cfg_index_t REG_FEEDBACK_GAIN = 3'd3;
  localparam cfg_index_t REG_WET_GAIN      = 3'd4;
  localparam cfg_index_t REG_DRY_GAIN      = 3'd5;

  localparam logic        [STEP_W-1:0]    PHASE_STEP_RST    = 20'd7107;
  localparam logic        [DLY_CFG_W-1:0] DELAY_BASE_RST    = 19'd0;
  localparam logic        [DLY_CFG_W-1:0] DELAY_SWING_RST   = 19'd94669;
  localparam logic signed [GAIN_W-1:0]    FEEDBACK_GAIN_RST = -16'sd12452;
  localparam logic        [GAIN_W-1:0]    WET_GAIN_RST      = 16'd15401;
  localparam logic        [GAIN_W-1:0]    DRY_GAIN_RST      = 16'd17367;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SHAPE,
    ST_ADDR,
    ST_READ_A,
    ST_READ_B,
    ST_LERP,
    ST_TAP,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_FB,
    MUL_DRY,
    MUL_LERP,
    MUL_WET
  } lane_op_t;

  typedef struct packed {
    logic     accept;
    logic     wr_en;
    logic     mul_en;
    lane_op_t mul_sel;
    logic     sq_en;
    logic     shape_en;
    logic     addr_en;
    logic     rd_sel;
    logic     cap_a;
    logic     tap_en;
    logic     out_load;
  } cmd_t;

endpackage

### sv/thru_zero_flanger_core.sv
// Top level of the stereo thru-zero flanger: configuration registers,
// sequencer and datapath. Depends on tzf_pkg, tzf_ctrl and tzf_dp.
//
// One stereo sample in, one stereo sample out. The next sample is accepted
// once the current one has passed every sequencer state, provided the
// previous result has been taken: the delay lines have one port each, so the
// line write and the two interpolation reads go in separate cycles, and each
// channel runs its feedback, dry, interpolation and wet products through one
// shared multiplier, while a second multiplier forms the phase square and the
// delay swing. The delay lines need no clearing after reset: entries not yet
// written read as zero. Configuration is taken in any cycle (cfg_ready is
// always high) but should only change while no sample is in flight.
module thru_zero_flanger_core #(
  parameter int DELAY_DEPTH = tzf_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = tzf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]          in_right_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_left_out,
  output logic signed [SAMPLE_BITS-1:0]          out_right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [tzf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [tzf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic        [tzf_pkg::STEP_W-1:0]    phase_step_r;
  logic        [tzf_pkg::DLY_CFG_W-1:0] delay_base_r;
  logic        [tzf_pkg::DLY_CFG_W-1:0] delay_swing_r;
  logic signed [tzf_pkg::GAIN_W-1:0]    feedback_gain_r;
  logic        [tzf_pkg::GAIN_W-1:0]    wet_gain_r;
  logic        [tzf_pkg::GAIN_W-1:0]    dry_gain_r;

  tzf_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= tzf_pkg::PHASE_STEP_RST;
      delay_base_r    <= tzf_pkg::DELAY_BASE_RST;
      delay_swing_r   <= tzf_pkg::DELAY_SWING_RST;
      feedback_gain_r <= tzf_pkg::FEEDBACK_GAIN_RST;
      wet_gain_r      <= tzf_pkg::WET_GAIN_RST;
      dry_gain_r      <= tzf_pkg::DRY_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tzf_pkg::REG_PHASE_STEP:    phase_step_r    <= cfg_data[tzf_pkg::STEP_W-1:0];
        tzf_pkg::REG_DELAY_BASE:    delay_base_r    <= cfg_data[tzf_pkg::DLY_CFG_W-1:0];
        tzf_pkg::REG_DELAY_SWING:   delay_swing_r   <= cfg_data[tzf_pkg::DLY_CFG_W-1:0];
        tzf_pkg::REG_FEEDBACK_GAIN: feedback_gain_r <= $signed(cfg_data[tzf_pkg::GAIN_W-1:0]);
        tzf_pkg::REG_WET_GAIN:      wet_gain_r      <= cfg_data[tzf_pkg::GAIN_W-1:0];
        tzf_pkg::REG_DRY_GAIN:      dry_gain_r      <= cfg_data[tzf_pkg::GAIN_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  tzf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tzf_dp #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .phase_step    (phase_step_r),
    .delay_base    (delay_base_r),
    .delay_swing   (delay_swing_r),
    .feedback_gain (feedback_gain_r),
    .wet_gain      (wet_gain_r),
    .dry_gain      (dry_gain_r),
    .left_in       (in_left_in),
    .right_in      (in_right_in),
    .left_out      (out_left_out),
    .right_out     (out_right_out)
  );

endmodule

### sv/tzf_lane.sv
// One audio channel of the flanger: delay memory, shared multiplier,
// feedback tap and output register. Depends on tzf_pkg.
module tzf_lane #(
  parameter int DELAY_DEPTH = tzf_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = tzf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tzf_pkg::cmd_t                          cmd,
  input  logic signed [tzf_pkg::GAIN_W-1:0]      feedback_gain,
  input  logic        [tzf_pkg::GAIN_W-1:0]      wet_gain,
  input  logic        [tzf_pkg::GAIN_W-1:0]      dry_gain,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  logic        [$clog2(DELAY_DEPTH)-1:0]  wr_addr,
  input  logic        [$clog2(DELAY_DEPTH)-1:0]  rd_addr,
  input  logic                                   rd_valid,
  input  logic        [tzf_pkg::FRAC_W-1:0]      frac,
  output logic signed [SAMPLE_BITS-1:0]          sample_out
);

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int A_W    = tzf_pkg::LANE_A_W;
  localparam int B_W    = SAMPLE_BITS + 1;
  localparam int P_W    = A_W + B_W;
  localparam int SAT_W  = SAMPLE_BITS + 4;
  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SAT_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-SAT_MAX - 1);
  localparam logic signed [P_W:0] RND_HALF = (P_W + 1)'(1) << (tzf_pkg::GAIN_FRAC - 1);

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic signed [SAMPLE_BITS-1:0] in_r;
  logic signed [SAMPLE_BITS-1:0] tap_r;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic signed [P_W-1:0]         prod_r;
  logic signed [P_W-1:0]         dry_r;

  logic signed [A_W-1:0]         op_a;
  logic signed [B_W-1:0]         op_b;
  logic signed [P_W-1:0]         prod_nxt;
  logic signed [SAMPLE_BITS-1:0] b_val;
  logic signed [B_W-1:0]         diff_ab;
  logic signed [P_W-1:0]         lerp_q;
  logic signed [B_W-1:0]         tap_sum;
  logic signed [SAMPLE_BITS-1:0] tap_nxt;
  logic signed [P_W:0]           fb_rnd;
  logic signed [P_W:0]           fb_sh;
  logic signed [SAT_W-1:0]       wsum;
  logic signed [SAMPLE_BITS-1:0] wdata;
  logic signed [P_W:0]           mix;
  logic signed [P_W:0]           mix_sh;
  logic signed [SAT_W-1:0]       mix_q;
  logic signed [SAMPLE_BITS-1:0] out_nxt;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_f(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      sat_f = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      sat_f = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_f = v[SAMPLE_BITS-1:0];
    end
  endfunction

  // Interpolation between the two taps; an unwritten entry reads as zero.
  assign b_val   = rd_valid ? rdata_r : '0;
  assign diff_ab = B_W'(b_val) - B_W'(a_r);
  assign lerp_q  = prod_r >>> tzf_pkg::FRAC_W;
  assign tap_sum = B_W'(a_r) + lerp_q[B_W-1:0];
  assign tap_nxt = tap_sum[SAMPLE_BITS-1:0];

  // Line input: sample plus rounded feedback product.
  assign fb_rnd = (P_W + 1)'(prod_r) + RND_HALF;
  assign fb_sh  = fb_rnd >>> tzf_pkg::GAIN_FRAC;
  assign wsum   = SAT_W'(in_r) + fb_sh[SAT_W-1:0];
  assign wdata  = sat_f(wsum);

  // Output: dry product minus wet product, rounded.
  assign mix     = (P_W + 1)'(dry_r) - (P_W + 1)'(prod_r) + RND_HALF;
  assign mix_sh  = mix >>> tzf_pkg::GAIN_FRAC;
  assign mix_q   = mix_sh[SAT_W-1:0];
  assign out_nxt = sat_f(mix_q);

  always_comb begin
    case (cmd.mul_sel)
      tzf_pkg::MUL_FB: begin
        op_a = A_W'(feedback_gain);
        op_b = B_W'(tap_r);
      end
      tzf_pkg::MUL_DRY: begin
        op_a = $signed({1'b0, dry_gain});
        op_b = B_W'(in_r);
      end
      tzf_pkg::MUL_LERP: begin
        op_a = $signed({{(A_W - tzf_pkg::FRAC_W){1'b0}}, frac});
        op_b = diff_ab;
      end
      tzf_pkg::MUL_WET: begin
        op_a = $signed({1'b0, wet_gain});
        op_b = B_W'(tap_nxt);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= sample_in;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.shape_en) begin
      dry_r <= prod_r;
    end
    if (cmd.cap_a) begin
      a_r <= rd_valid ? rdata_r : '0;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (cmd.tap_en) begin
      tap_r <= tap_nxt;
    end
  end

  assign sample_out = out_r;

endmodule

### sv/tzf_dp.sv
// Datapath of the flanger: phase accumulator, write pointer, delay and tap
// address arithmetic, and the two channel lanes. Depends on tzf_pkg, tzf_lane.
module tzf_dp #(
  parameter int DELAY_DEPTH = tzf_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = tzf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tzf_pkg::cmd_t                        cmd,
  input  logic        [tzf_pkg::STEP_W-1:0]    phase_step,
  input  logic        [tzf_pkg::DLY_CFG_W-1:0] delay_base,
  input  logic        [tzf_pkg::DLY_CFG_W-1:0] delay_swing,
  input  logic signed [tzf_pkg::GAIN_W-1:0]    feedback_gain,
  input  logic        [tzf_pkg::GAIN_W-1:0]    wet_gain,
  input  logic        [tzf_pkg::GAIN_W-1:0]    dry_gain,
  input  logic signed [SAMPLE_BITS-1:0]        left_in,
  input  logic signed [SAMPLE_BITS-1:0]        right_in,
  output logic signed [SAMPLE_BITS-1:0]        left_out,
  output logic signed [SAMPLE_BITS-1:0]        right_out
);

  localparam int ADDR_W  = $clog2(DELAY_DEPTH);
  localparam int WHOLE_W = tzf_pkg::WHOLE_W;
  localparam int SUM_W   = ((WHOLE_W > ADDR_W) ? WHOLE_W : ADDR_W) + 1;
  localparam int WRAP_STEPS = ((1 << WHOLE_W) + DELAY_DEPTH - 1) / DELAY_DEPTH;
  localparam int PW      = tzf_pkg::PHASE_W;
  localparam int SQ_W    = 2 * PW - 1;
  localparam int SW_LO   = PW - 1;
  localparam int SW_HI   = SW_LO + tzf_pkg::DELAY_W - 1;
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(DELAY_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(DELAY_DEPTH - 1);
  localparam logic [SQ_W-1:0]   SQ_ONE   = {1'b1, {(SQ_W - 1){1'b0}}};

  logic [PW-1:0]                     phase_r;
  logic [ADDR_W-1:0]                 wp_r;
  logic                              filled_r;
  logic signed [tzf_pkg::PROD_A_W-1:0] prod_a_r;
  logic [ADDR_W-1:0]                 i0_r;
  logic [ADDR_W-1:0]                 i1_r;
  logic [tzf_pkg::FRAC_W-1:0]        frac_r;
  logic                              rd_valid_r;

  logic [PW-1:0]                     phase_nxt;
  logic [ADDR_W-1:0]                 wp_nxt;
  logic signed [tzf_pkg::MUL_A_W-1:0] ma;
  logic signed [tzf_pkg::MUL_A_W-1:0] mb;
  logic signed [tzf_pkg::PROD_A_W-1:0] prod_a_nxt;
  logic [SQ_W-1:0]                   shape_diff;
  logic [PW-1:0]                     shape;
  logic [tzf_pkg::DELAY_W-1:0]       delay;
  logic [WHOLE_W-1:0]                whole;
  logic [SUM_W-1:0]                  tap_sum;
  logic [ADDR_W-1:0]                 i0_nxt;
  logic [ADDR_W-1:0]                 i1_nxt;
  logic [ADDR_W-1:0]                 rd_addr;

  assign phase_nxt = (phase_step == '0) ? '0 : phase_r + PW'(phase_step);
  assign wp_nxt    = (wp_r == '0) ? ADDR_TOP : wp_r - 1'b1;

  // 1 - p^2 scaled to Q1.31; p*p never exceeds 2^62.
  assign shape_diff = SQ_ONE - prod_a_r[SQ_W-1:0];
  assign shape      = shape_diff[SQ_W-1:SQ_W-PW];

  always_comb begin
    if (cmd.shape_en) begin
      ma = $signed(tzf_pkg::MUL_A_W'(delay_swing));
      mb = $signed({1'b0, shape});
    end else begin
      ma = $signed({phase_r[PW-1], phase_r});
      mb = $signed({phase_r[PW-1], phase_r});
    end
  end

  assign prod_a_nxt = ma * mb;

  assign delay = tzf_pkg::DELAY_W'(delay_base) + prod_a_r[SW_HI:SW_LO];
  assign whole = delay[tzf_pkg::DELAY_W-1:tzf_pkg::FRAC_W];

  // Reduce the tap position modulo the line depth.
  always_comb begin
    tap_sum = SUM_W'(whole) + SUM_W'(wp_r);
    for (int k = 0; k < WRAP_STEPS; k++) begin
      if (tap_sum >= DEPTH_S) begin
        tap_sum = tap_sum - DEPTH_S;
      end
    end
  end

  assign i0_nxt  = tap_sum[ADDR_W-1:0];
  assign i1_nxt  = (i0_nxt == ADDR_TOP) ? '0 : i0_nxt + 1'b1;
  assign rd_addr = cmd.rd_sel ? i1_r : i0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      wp_r     <= '0;
      filled_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        wp_r    <= wp_nxt;
      end
      // Entries fill downward from the top; writing entry zero completes the line.
      if (cmd.wr_en && wp_r == '0) begin
        filled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en || cmd.shape_en) begin
      prod_a_r <= prod_a_nxt;
    end
    if (cmd.addr_en) begin
      i0_r   <= i0_nxt;
      i1_r   <= i1_nxt;
      frac_r <= delay[tzf_pkg::FRAC_W-1:0];
    end
    rd_valid_r <= filled_r || (rd_addr >= wp_r);
  end

  tzf_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .feedback_gain (feedback_gain),
    .wet_gain      (wet_gain),
    .dry_gain      (dry_gain),
    .sample_in     (left_in),
    .wr_addr       (wp_r),
    .rd_addr       (rd_addr),
    .rd_valid      (rd_valid_r),
    .frac          (frac_r),
    .sample_out    (left_out)
  );

  tzf_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .feedback_gain (feedback_gain),
    .wet_gain      (wet_gain),
    .dry_gain      (dry_gain),
    .sample_in     (right_in),
    .wr_addr       (wp_r),
    .rd_addr       (rd_addr),
    .rd_valid      (rd_valid_r),
    .frac          (frac_r),
    .sample_out    (right_out)
  );

endmodule

### sv/tzf_ctrl.sv
// Sequencer of the flanger: steps one sample through the datapath and owns
// the input stall and output valid. Depends on tzf_pkg and the assert header.
`include "thru_zero_flanger_core_assert.svh"

module tzf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tzf_pkg::cmd_t cmd
);

  tzf_pkg::state_t state_r;
  tzf_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tzf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      tzf_pkg::ST_IDLE: begin
        // keep the feedback product current so it is ready at accept
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tzf_pkg::MUL_FB;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tzf_pkg::ST_WRITE;
        end
      end
      tzf_pkg::ST_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.sq_en   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tzf_pkg::MUL_DRY;
        state_nxt   = tzf_pkg::ST_SHAPE;
      end
      tzf_pkg::ST_SHAPE: begin
        cmd.shape_en = 1'b1;
        state_nxt    = tzf_pkg::ST_ADDR;
      end
      tzf_pkg::ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = tzf_pkg::ST_READ_A;
      end
      tzf_pkg::ST_READ_A: begin
        state_nxt = tzf_pkg::ST_READ_B;
      end
      tzf_pkg::ST_READ_B: begin
        cmd.rd_sel = 1'b1;
        cmd.cap_a  = 1'b1;
        state_nxt  = tzf_pkg::ST_LERP;
      end
      tzf_pkg::ST_LERP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tzf_pkg::MUL_LERP;
        state_nxt   = tzf_pkg::ST_TAP;
      end
      tzf_pkg::ST_TAP: begin
        cmd.tap_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tzf_pkg::MUL_WET;
        state_nxt   = tzf_pkg::ST_OUT;
      end
      tzf_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tzf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tzf_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != tzf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `TZF_ASSERT_NXT(a_accept_to_write, cmd.accept, state_r == tzf_pkg::ST_WRITE, "accept not followed by line write")
  `TZF_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall), "pending output overwritten")
  `TZF_ASSERT_IMP(a_valid_from_load, $rose(out_valid_r), $past(cmd.out_load), "output valid without load")
  `TZF_ASSERT_NXT(a_out_hold, state_r == tzf_pkg::ST_OUT && out_valid_r && out_stall, state_r == tzf_pkg::ST_OUT, "left output state while blocked")

endmodule
